FILE: hdl/cdfw_pkg.sv
// Shared constants and request codes for the character display frame writer.
package cdfw_pkg;

  // Default display geometry.
  localparam int DEF_LINES      = 2;
  localparam int DEF_LINE_CHARS = 16;

  // Field widths.
  localparam int FUNC_W  = 4;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 5;
  localparam int ADDR_W  = 7;
  localparam int NUM_W   = 32;
  localparam int FRAME_W = 10;

  // Decimal conversion: ten BCD digits cover a 32-bit value.
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int DCNT_W     = $clog2(BCD_DIGITS + 1);

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_PUT_CURSOR = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUT_POS    = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_ADDR   = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_DECIMAL    = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_DISP_CTL   = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_ENTRY      = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_SHIFT      = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_HOME       = 4'd8;

  // Command bytes.
  localparam logic [CHAR_W-1:0] CMD_SET_ADDR = 8'h80;
  localparam logic [CHAR_W-1:0] CMD_DISP_CTL = 8'h08;
  localparam logic [CHAR_W-1:0] CMD_ENTRY    = 8'h04;
  localparam logic [CHAR_W-1:0] CMD_SHIFT    = 8'h10;
  localparam logic [CHAR_W-1:0] CMD_CLEAR    = 8'h01;
  localparam logic [CHAR_W-1:0] CMD_HOME     = 8'h02;

  // Address map of the display memory.
  localparam logic [ADDR_W-1:0] LINE2_BASE     = 7'h40;
  localparam logic [ADDR_W-1:0] LINE1_LAST     = 7'h0F;
  localparam logic [ADDR_W-1:0] LINE2_LAST     = 7'h4F;

  // ASCII code of the digit zero, upper nibble.
  localparam logic [3:0] DIGIT_HI = 4'h3;

  // Frame type marks in bits 9..8.
  localparam logic [1:0] FRAME_CMD  = 2'b00;
  localparam logic [1:0] FRAME_DATA = 2'b10;

endpackage

FILE: hdl/cdfw_bcd.sv
// Bit-serial binary to BCD converter, one input bit per cycle.
module cdfw_bcd import cdfw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] value,
  output logic             done,
  output logic [BCD_W-1:0] digits
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] adj;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Control: a busy flag and the bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(NUM_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Shift the binary value into the digit register, most significant bit first.
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[NUM_W-2:0], 1'b0};
      bcd <= {adj[BCD_W-2:0], bin[NUM_W-1]};
    end
  end

  assign digits = bcd;

endmodule

FILE: hdl/char_display_frame_writer.sv
// Top level of the character display frame writer: request sequencer and output register.
//
//   channel | handshake          | words
//   --------+--------------------+--------------------------------------------------
//   in      | in_valid, in_stall | func, char_code, position, ddram_address, number,
//           |                    | flag_a, flag_b, flag_c
//   out     | out_valid,out_stall| frame, last
//
// A command request goes through S_ONE, which loads its frame once the output can take it;
// then the sequencer returns to idle for the next request. A set-address request outside
// both line ranges is dropped. A put request gives two frames, an address command and a
// data word; a put to a position past the last cell gives none. A decimal request waits in
// S_CONV for the bit-serial converter, drops each leading zero digit in S_SKIP (the last
// digit always stays), then per digit goes through S_SKIP (digit load), S_ADDR (address
// frame) and S_DATA (data frame). Reset clears the cursor, the sequencer and out_valid.
// An output stall holds the sequencer in frame states; in_stall is high while it works.
module char_display_frame_writer import cdfw_pkg::*; #(
  parameter int LINES      = DEF_LINES,
  parameter int LINE_CHARS = DEF_LINE_CHARS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic [POS_W-1:0]    position,
  input  logic [ADDR_W-1:0]   ddram_address,
  input  logic [NUM_W-1:0]    number,
  input  logic                flag_a,
  input  logic                flag_b,
  input  logic                flag_c,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FRAME_W-1:0]  frame,
  output logic                last
);

  localparam int CELLS  = LINES * LINE_CHARS;
  localparam int CELL_W = $clog2(CELLS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_ADDR = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;
  localparam logic [2:0] S_ONE  = 3'd5;

  logic [2:0]        state;
  logic [CELL_W-1:0] cursor;
  logic [CELL_W-1:0] cursor_next;
  logic [CELL_W-1:0] cell_idx;
  logic [CHAR_W-1:0] ch;
  logic [CHAR_W-1:0] cmd;
  logic [BCD_W-1:0]  digits;
  logic [DCNT_W-1:0] dcnt;
  logic              leading;
  logic              digit_mode;
  logic              adv_cursor;
  logic              in_accept;
  logic              emit_ok;
  logic              load;
  logic              bcd_done;
  logic [BCD_W-1:0]  bcd_digits;
  logic [ADDR_W-1:0] cell_addr;
  logic              addr_bad;
  logic              pos_ok;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign emit_ok   = !out_valid || !out_stall;

  // Decimal converter.
  cdfw_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (in_accept && (func == FUNC_DECIMAL)),
    .value  (number),
    .done   (bcd_done),
    .digits (bcd_digits)
  );

  // Line mapping of a cell index to a display address.
  always_comb begin
    if (ADDR_W'(cell_idx) < ADDR_W'(LINE_CHARS)) begin
      cell_addr = ADDR_W'(cell_idx);
    end else begin
      cell_addr = ADDR_W'(cell_idx) + LINE2_BASE - ADDR_W'(LINE_CHARS);
    end
  end

  // Request checks and cursor advance with wrap after the last cell.
  assign addr_bad = ((ddram_address > LINE1_LAST) && (ddram_address < LINE2_BASE)) ||
                    (ddram_address > LINE2_LAST);
  assign pos_ok   = ADDR_W'(position) < ADDR_W'(CELLS);
  assign cursor_next = (ADDR_W'(cursor) + ADDR_W'(1) >= ADDR_W'(CELLS)) ?
                       '0 : cursor + CELL_W'(1);

  assign load = emit_ok && ((state == S_ADDR) || (state == S_DATA) || (state == S_ONE));

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor     <= '0;
      digit_mode <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            digit_mode <= (func == FUNC_DECIMAL);
            unique case (func)
              FUNC_PUT_CURSOR: state <= S_ADDR;
              FUNC_PUT_POS:    state <= pos_ok ? S_ADDR : S_IDLE;
              FUNC_SET_ADDR:   state <= addr_bad ? S_IDLE : S_ONE;
              FUNC_DECIMAL:    state <= S_CONV;
              FUNC_DISP_CTL, FUNC_ENTRY, FUNC_SHIFT, FUNC_CLEAR, FUNC_HOME: state <= S_ONE;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CONV: begin
          if (bcd_done) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (!(leading && (digits[BCD_W-1 -: 4] == 4'd0) && (dcnt > DCNT_W'(1)))) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (emit_ok) begin
            state <= S_DATA;
          end
        end
        S_DATA: begin
          if (emit_ok) begin
            if (adv_cursor) begin
              cursor <= cursor_next;
            end
            if (digit_mode && (dcnt > DCNT_W'(1))) begin
              state <= S_SKIP;
            end else begin
              state      <= S_IDLE;
              digit_mode <= 1'b0;
            end
          end
        end
        S_ONE: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    priority if (in_accept) begin
      cell_idx   <= (func == FUNC_PUT_POS) ? CELL_W'(position) : cursor;
      ch         <= char_code;
      adv_cursor <= (func == FUNC_PUT_CURSOR) || (func == FUNC_DECIMAL);
      unique case (func)
        FUNC_SET_ADDR: cmd <= CMD_SET_ADDR | {1'b0, ddram_address};
        FUNC_DISP_CTL: cmd <= CMD_DISP_CTL | {5'd0, flag_a, flag_b, flag_c};
        FUNC_ENTRY:    cmd <= CMD_ENTRY | {6'd0, flag_a, flag_b};
        FUNC_SHIFT:    cmd <= CMD_SHIFT | {4'd0, flag_a, flag_b, 2'b00};
        FUNC_CLEAR:    cmd <= CMD_CLEAR;
        FUNC_HOME:     cmd <= CMD_HOME;
        default:       cmd <= '0;
      endcase
    end else if ((state == S_CONV) && bcd_done) begin
      digits  <= bcd_digits;
      dcnt    <= DCNT_W'(BCD_DIGITS);
      leading <= 1'b1;
    end else if (state == S_SKIP) begin
      if (leading && (digits[BCD_W-1 -: 4] == 4'd0) && (dcnt > DCNT_W'(1))) begin
        digits <= {digits[BCD_W-5:0], 4'd0};
        dcnt   <= dcnt - DCNT_W'(1);
      end else begin
        ch       <= {DIGIT_HI, digits[BCD_W-1 -: 4]};
        cell_idx <= cursor;
        leading  <= 1'b0;
      end
    end else if ((state == S_DATA) && emit_ok && digit_mode) begin
      digits <= {digits[BCD_W-5:0], 4'd0};
      dcnt   <= dcnt - DCNT_W'(1);
    end else begin
      // Nothing to update in this cycle.
    end
  end

  // Output register: valid flag under reset, word fields loaded by the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unique case (state)
        S_ADDR: begin
          frame <= {FRAME_CMD, CMD_SET_ADDR | {1'b0, cell_addr}};
          last  <= 1'b0;
        end
        S_DATA: begin
          frame <= {FRAME_DATA, ch};
          last  <= !digit_mode || (dcnt == DCNT_W'(1));
        end
        default: begin
          frame <= {FRAME_CMD, cmd};
          last  <= 1'b1;
        end
      endcase
    end
  end

  // The cursor always points at a cell of the display.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    ADDR_W'(cursor) < ADDR_W'(CELLS))
    else $error("cursor beyond last cell");

  // Loading the final word of a command or put request returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load && ((state == S_ONE) || ((state == S_DATA) && !digit_mode))) |=> (state == S_IDLE))
    else $error("sequencer busy after final word");

  // While digits are sent, the digit count stays between one and the number of digit slots.
  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SKIP) || (digit_mode && (state == S_DATA)))
      |-> ((dcnt != '0) && (dcnt <= DCNT_W'(BCD_DIGITS))))
    else $error("digit count out of range");

endmodule

FILE: tb/char_display_frame_writer_tb.sv
// Self-checking testbench for the character display frame writer.
`timescale 1ns / 100ps

module char_display_frame_writer_tb;
  import cdfw_pkg::*;

  localparam int CELLS          = DEF_LINES * DEF_LINE_CHARS;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 100;
  localparam int PHASE_ITEMS    = 100;
  localparam int PRESSURE_ITEMS = 45;
  localparam int REPORT_LIMIT   = 10;

  // Selector codes that the block ignores.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = FUNC_HOME + 1'b1;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = '1;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic [ADDR_W-1:0] ddram_address;
    logic [NUM_W-1:0]  number;
    logic              flag_a;
    logic              flag_b;
    logic              flag_c;
  } display_request_t;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic               last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  func          = '0;
  logic [CHAR_W-1:0]  char_code     = '0;
  logic [POS_W-1:0]   position      = '0;
  logic [ADDR_W-1:0]  ddram_address = '0;
  logic [NUM_W-1:0]   number        = '0;
  logic               flag_a        = 1'b0;
  logic               flag_b        = 1'b0;
  logic               flag_c        = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [FRAME_W-1:0] frame;
  logic               last;

  display_request_t request_queue[$];
  display_request_t active_req;
  frame_word_t      frames_due[$];
  int unsigned      display_cursor = 0;
  int               error_count    = 0;

  // Traffic shaping, set by the sequence between phases.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_toggle   = 1'b0;
  logic        hold_seen     = 1'b0;
  int unsigned hold_left     = 0;

  char_display_frame_writer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .char_code     (char_code),
    .position      (position),
    .ddram_address (ddram_address),
    .number        (number),
    .flag_a        (flag_a),
    .flag_b        (flag_b),
    .flag_c        (flag_c),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame         (frame),
    .last          (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Set-address command for a cell, with line two based at its own address.
  function automatic logic [FRAME_W-1:0] address_word(input int unsigned cell_idx);
    logic [ADDR_W-1:0] addr;
    if (cell_idx < DEF_LINE_CHARS) begin
      addr = ADDR_W'(cell_idx);
    end else begin
      addr = LINE2_BASE + ADDR_W'(cell_idx - DEF_LINE_CHARS);
    end
    return {FRAME_CMD, CMD_SET_ADDR | {1'b0, addr}};
  endfunction

  function automatic logic [FRAME_W-1:0] data_word(input logic [CHAR_W-1:0] ch);
    return {FRAME_DATA, ch};
  endfunction

  // Works out the words a request produces and updates the cursor copy.
  task automatic predict_frames(input display_request_t req);
    logic [FRAME_W-1:0] words[$];
    logic [3:0]         digits[$];
    logic [NUM_W-1:0]   value;
    frame_word_t        fw;
    case (req.func)
      FUNC_PUT_CURSOR, FUNC_DECIMAL: begin
        if (req.func == FUNC_DECIMAL) begin
          // Digits most significant first; zero prints a single digit.
          value = req.number;
          do begin
            digits.push_front(4'(value % 10));
            value = value / 10;
          end while (value != 0);
        end else begin
          digits.push_back(4'd0);
        end
        foreach (digits[i]) begin
          words.push_back(address_word(display_cursor));
          if (req.func == FUNC_DECIMAL) begin
            words.push_back(data_word({DIGIT_HI, digits[i]}));
          end else begin
            words.push_back(data_word(req.char_code));
          end
          display_cursor = (display_cursor + 1 >= CELLS) ? 0 : display_cursor + 1;
        end
      end
      FUNC_PUT_POS: begin
        if (req.position < CELLS) begin
          words.push_back(address_word(req.position));
          words.push_back(data_word(req.char_code));
        end
      end
      FUNC_SET_ADDR: begin
        if (req.ddram_address <= LINE1_LAST ||
            (req.ddram_address >= LINE2_BASE && req.ddram_address <= LINE2_LAST)) begin
          words.push_back({FRAME_CMD, CMD_SET_ADDR | {1'b0, req.ddram_address}});
        end
      end
      FUNC_DISP_CTL: begin
        words.push_back({FRAME_CMD,
                         CMD_DISP_CTL | {5'b0, req.flag_a, req.flag_b, req.flag_c}});
      end
      FUNC_ENTRY: begin
        words.push_back({FRAME_CMD, CMD_ENTRY | {6'b0, req.flag_a, req.flag_b}});
      end
      FUNC_SHIFT: begin
        words.push_back({FRAME_CMD, CMD_SHIFT | {4'b0, req.flag_a, req.flag_b, 2'b0}});
      end
      FUNC_CLEAR: begin
        words.push_back({FRAME_CMD, CMD_CLEAR});
      end
      FUNC_HOME: begin
        words.push_back({FRAME_CMD, CMD_HOME});
      end
      default: begin
      end
    endcase
    foreach (words[i]) begin
      fw.frame = words[i];
      fw.last  = (i == words.size() - 1);
      frames_due.push_back(fw);
    end
  endtask

  function automatic display_request_t directed_request(input logic [FUNC_W-1:0] f,
                                                        input logic [CHAR_W-1:0] ch,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic [ADDR_W-1:0] addr,
                                                        input logic [NUM_W-1:0] num,
                                                        input logic [2:0] flags);
    display_request_t r;
    r.func          = f;
    r.char_code     = ch;
    r.position      = pos;
    r.ddram_address = addr;
    r.number        = num;
    {r.flag_a, r.flag_b, r.flag_c} = flags;
    return r;
  endfunction

  // Random request: every field random, the selector and some fields biased.
  function automatic display_request_t random_request();
    display_request_t r;
    int unsigned      sel;
    logic [NUM_W-1:0] scale;
    r.char_code     = CHAR_W'($urandom_range(255));
    r.position      = POS_W'($urandom_range(CELLS - 1));
    r.number        = $urandom;
    r.flag_a        = 1'($urandom_range(1));
    r.flag_b        = 1'($urandom_range(1));
    r.flag_c        = 1'($urandom_range(1));
    // Half the raw addresses are drawn from a valid line range, the other half from all 128.
    if ($urandom_range(1)) begin
      r.ddram_address = $urandom_range(1) ? ADDR_W'($urandom_range(LINE1_LAST))
                                          : LINE2_BASE + ADDR_W'($urandom_range(15));
    end else begin
      r.ddram_address = ADDR_W'($urandom_range(127));
    end
    sel = $urandom_range(99);
    if (sel < 32)      r.func = FUNC_PUT_CURSOR;
    else if (sel < 47) r.func = FUNC_PUT_POS;
    else if (sel < 57) r.func = FUNC_SET_ADDR;
    else if (sel < 72) r.func = FUNC_DECIMAL;
    else if (sel < 77) r.func = FUNC_DISP_CTL;
    else if (sel < 82) r.func = FUNC_ENTRY;
    else if (sel < 87) r.func = FUNC_SHIFT;
    else if (sel < 91) r.func = FUNC_CLEAR;
    else if (sel < 95) r.func = FUNC_HOME;
    else r.func = FUNC_UNUSED_LO + FUNC_W'($urandom_range(FUNC_UNUSED_HI - FUNC_UNUSED_LO));
    // Numbers: short ones, full range, around powers of ten, and zero.
    case ($urandom_range(3))
      0: r.number = $urandom_range(99);
      1: r.number = $urandom;
      2: begin
        scale = 1;
        repeat ($urandom_range(9)) scale = scale * 10;
        r.number = scale - $urandom_range(1);
      end
      default: r.number = '0;
    endcase
    return r;
  endfunction

  // Driver: offers queued requests and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_frames(active_req);
      end
      if (!in_valid || !in_stall) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          active_req     = request_queue.pop_front();
          func          <= active_req.func;
          char_code     <= active_req.char_code;
          position      <= active_req.position;
          ddram_address <= active_req.ddram_address;
          number        <= active_req.number;
          flag_a        <= active_req.flag_a;
          flag_b        <= active_req.flag_b;
          flag_c        <= active_req.flag_c;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, or held for a long stretch when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    frame_word_t fw;
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        error_count <= error_count + 1;
        if (error_count < REPORT_LIMIT) begin
          $display("%0t: unexpected word: frame %h last %0d", $realtime, frame, last);
        end
      end else begin
        fw = frames_due.pop_front();
        if (frame !== fw.frame || last !== fw.last) begin
          error_count <= error_count + 1;
          if (error_count < REPORT_LIMIT) begin
            $display("%0t: mismatch: expected frame %h last %0d, got frame %h last %0d",
                     $realtime, fw.frame, fw.last, frame, last);
          end
        end
      end
    end
  end

  // Waits until every request is taken and every expected word has come.
  task automatic wait_for_drain();
    while (request_queue.size() != 0 || in_valid || frames_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Stimulus sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, every request kind and the edge cases.
    request_queue.push_back(directed_request(FUNC_PUT_CURSOR, 8'h00, '0, '0, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_PUT_CURSOR, 8'hFF, '1, '1, '1, 3'b111));
    request_queue.push_back(directed_request(FUNC_PUT_POS, 8'h41, 5'd0, '0, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_PUT_POS, 8'h42, 5'd15, '0, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_PUT_POS, 8'h43, 5'd16, '0, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_PUT_POS, 8'hFF, 5'd31, '1, '1, 3'b111));
    request_queue.push_back(directed_request(FUNC_SET_ADDR, '0, '0, 7'h00, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_SET_ADDR, '0, '0, LINE1_LAST, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_SET_ADDR, '0, '0, 7'h10, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_SET_ADDR, '0, '0, 7'h3F, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_SET_ADDR, '0, '0, LINE2_BASE, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_SET_ADDR, '0, '0, LINE2_LAST, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_SET_ADDR, '0, '0, 7'h50, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_SET_ADDR, '0, '0, 7'h7F, '0, 3'b000));
    request_queue.push_back(directed_request(FUNC_DECIMAL, '0, '0, '0, 32'd0, 3'b000));
    request_queue.push_back(directed_request(FUNC_DECIMAL, '0, '0, '0, '1, 3'b000));
    request_queue.push_back(directed_request(FUNC_DECIMAL, '0, '0, '0, 32'd1000000007,
                                             3'b000));
    request_queue.push_back(directed_request(FUNC_DECIMAL, '0, '0, '0, 32'd10, 3'b000));
    request_queue.push_back(directed_request(FUNC_DISP_CTL, '0, '0, '0, '0, 3'b111));
    request_queue.push_back(directed_request(FUNC_ENTRY, '0, '0, '0, '0, 3'b110));
    request_queue.push_back(directed_request(FUNC_SHIFT, '0, '0, '0, '0, 3'b110));
    request_queue.push_back(directed_request(FUNC_CLEAR, '1, '1, '1, '1, 3'b111));
    request_queue.push_back(directed_request(FUNC_HOME, '1, '1, '1, '1, 3'b111));
    request_queue.push_back(directed_request(FUNC_UNUSED_LO, '1, '1, '1, '1, 3'b111));
    request_queue.push_back(directed_request(FUNC_UNUSED_HI, '1, '1, '1, '1, 3'b111));
    wait_for_drain();

    // Random phases with different idling on each side; the sender pauses between them.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      repeat (PHASE_ITEMS) request_queue.push_back(random_request());
      wait_for_drain();
    end

    // Long receiver hold while the sender keeps offering, so the input backs up.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_toggle   = ~hold_toggle;
    repeat (PRESSURE_ITEMS) request_queue.push_back(random_request());
    wait_for_drain();

    // Let any stray word show up before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
